### rtl/bse_pkg.sv
`default_nettype none

package bse_pkg;

   localparam int WORD_BITS     = 32;
   localparam int SIZE_BITS_DEF = 1024;
   localparam int SIZE_W        = 11;
   localparam int POS_W         = 10;
   localparam int FUNC_W        = 4;
   localparam int CNT_W         = 10;
   localparam int WIDX_W        = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // register index taken from the word address bits of paddr
   localparam logic REG_SIZE_IN_USE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FN_WRITE_BIT  = 4'd0,
      FN_TEST       = 4'd1,
      FN_RANGE      = 4'd2,
      FN_ALL        = 4'd3,
      FN_INVERT_ALL = 4'd4,
      FN_INVERT_BIT = 4'd5,
      FN_FIND       = 4'd6,
      FN_WRITE_WORD = 4'd7,
      FN_SHIFT_UP   = 4'd8,
      FN_SHIFT_DN   = 4'd9
   } func_type;

   typedef struct packed {
      logic              start;
      logic [CNT_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] rem;
   } div_sts_type;

endpackage

`default_nettype wire

### rtl/bse_if.sv
`default_nettype none

interface bse_req_if;
   import bse_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  bit_pos;
   logic [POS_W-1:0]  range_end;
   logic              bit_value;
   logic [CNT_W-1:0]  shift_count;
   logic [WIDX_W-1:0] word_index;
   logic [31:0]       word_data;

   modport source (output valid, func, bit_pos, range_end, bit_value, shift_count,
                   word_index, word_data, input ready);
   modport sink (input valid, func, bit_pos, range_end, bit_value, shift_count,
                 word_index, word_data, output ready);
endinterface

interface bse_rsp_if;
   import bse_pkg::*;
   logic             valid;
   logic             ready;
   logic             test_bit;
   logic             found;
   logic [POS_W-1:0] found_pos;
   logic             any_set;
   logic             all_set;
   logic             out_of_range;

   modport source (output valid, test_bit, found, found_pos, any_set, all_set,
                   out_of_range, input ready);
   modport sink (input valid, test_bit, found, found_pos, any_set, all_set,
                 out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/bitmap_set_engine.sv
`default_nettype none

// Bitmap of SIZE_BITS bits kept as 32-bit words in one single-port-read,
// single-port-write memory. Every item walks the whole memory once: word by
// word it is read, modified for the operation and written back, while any_set,
// all_set, the search and the test are gathered on the way. The walk reads
// one word per cycle; shifts first pass through the bit-serial modulo unit
// before the walk. One item is worked on at a time; a finished result waits
// in the output register while the next item runs. There is no clearing pass
// after reset: words beyond the size of the last completed walk read as
// zero, and a shrink of size_in_use takes effect the same way, so stale
// bits never come back when the size grows again.
module bitmap_set_engine #(
   parameter int SIZE_BITS = bse_pkg::SIZE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bse_req_if.sink                         req,
   bse_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bse_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bse_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bse_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bse_pkg::*;

   localparam int NW   = (SIZE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
   localparam int ST_W = $clog2(NW + 2);
   localparam int SA_W = ((AW > 5) ? AW : 5) + 3;
   localparam int CW   = (AW > 6) ? AW : 6;
   localparam int BW   = ((AW + 5) > SIZE_W) ? (AW + 5) : SIZE_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      if (s == '0) return SIZE_W'(1);
      if (int'(s) > SIZE_BITS) return SIZE_W'(SIZE_BITS);
      return s;
   endfunction

   function automatic logic [31:0] live_mask(input logic [AW-1:0] wi,
                                             input logic [SIZE_W-1:0] lim);
      logic [BW-1:0] base;
      logic [BW-1:0] lim_x;
      logic [BW-1:0] diff;
      base  = BW'(wi) << 5;
      lim_x = BW'(lim);
      if (base >= lim_x) return '0;
      diff = lim_x - base;
      if (diff >= BW'(32)) return '1;
      return ~(32'hFFFF_FFFF << diff[4:0]);
   endfunction

   // control and configuration
   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  lw_ff, lw_in;
   logic [SIZE_W-1:0]  n, nm1, new_n;
   logic               csr_wr;

   // latched item
   func_type           func_ff, func_in;
   logic               val_ff, val_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [31:0]        wdata_ff, wdata_in;
   logic [SIZE_W-1:0]  start_ff, start_in;
   logic [SIZE_W-1:0]  end_ff, end_in;
   logic               mod_ff, mod_in;
   logic               inv_ff, inv_in;
   logic               oor_ff, oor_in;
   logic               up_ff, up_in;
   logic [CNT_W-1:0]   k_ff, k_in;

   // walk
   logic [ST_W-1:0]    step_ff, step_in;
   logic               b_act_ff, b_act_in;
   logic [ST_W-1:0]    b_step_ff, b_step_in;
   logic               rok_ff, rok_in;
   logic [AW-1:0]      raddr_ff, raddr_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        rdat_ff;
   logic [31:0]        mem [NW];

   // gathered results
   logic               any_ff, any_in;
   logic               all_ff, all_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   fpos_ff, fpos_in;
   logic               tbit_ff, tbit_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_tbit_ff, rsp_found_ff, rsp_any_ff, rsp_all_ff, rsp_oor_ff;
   logic [POS_W-1:0]   rsp_fpos_ff;
   logic               rsp_load;

   // combinational helpers
   logic               acc;
   func_type           req_fn;
   logic [SIZE_W-1:0]  pos_x, rend_x, rend_c;
   logic               pos_oor, widx_bad;
   logic [WIDX_W+1:0]  nlw;
   logic [4:0]         q, r;
   logic [SA_W-1:0]    sa;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [ST_W-1:0]    wi_full;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        cur, base_w, lm, ge, le, rm, mm, new_w, pol, cand, iso;
   logic [CW-1:0]      wi_c, sw_c, ew_c;
   logic [4:0]         idx;
   logic [5:0]         back_amt;
   logic               sweep_end;

   div_ctl_type        div_ctl;
   div_sts_type        div_sts;

   bse_mod_div u_mod_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign n      = clamp_size(size_ff);
   assign nm1    = n - 1'b1;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite &&
                   (paddr[CSR_ADDR_W-1:2] == REG_SIZE_IN_USE);
   assign new_n  = clamp_size(pwdata[SIZE_W-1:0]);
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_SIZE_IN_USE) ?
                   CSR_DATA_W'(size_ff) : '0;

   assign req.ready = (state_ff == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign req_fn    = func_type'(req.func);

   assign div_ctl.start    = acc && (req_fn == FN_SHIFT_UP || req_fn == FN_SHIFT_DN);
   assign div_ctl.dividend = req.shift_count;
   assign div_ctl.divisor  = n;

   // item decode at accept
   always_comb begin
      pos_x    = {1'b0, req.bit_pos};
      rend_x   = {1'b0, req.range_end};
      rend_c   = (rend_x > nm1) ? nm1 : rend_x;
      pos_oor  = (pos_x >= n);
      nlw      = (WIDX_W+2)'((12'(n) + 12'd31) >> 5);
      widx_bad = ({2'b00, req.word_index} >= nlw) || (int'(req.word_index) >= NW);
      oor_in   = 1'b0;
      start_in = pos_x;
      end_in   = pos_x;
      mod_in   = 1'b0;
      inv_in   = 1'b0;
      up_in    = 1'b0;
      case (req_fn) inside
         FN_WRITE_BIT, FN_INVERT_BIT: begin
            oor_in = pos_oor;
            mod_in = !pos_oor;
            inv_in = (req_fn == FN_INVERT_BIT);
         end
         FN_TEST: begin
            oor_in = pos_oor;
         end
         FN_FIND: begin
            oor_in = pos_oor;
            end_in = nm1;
         end
         FN_RANGE: begin
            oor_in = pos_oor;
            end_in = rend_c;
            mod_in = !pos_oor && (pos_x <= rend_c);
         end
         FN_ALL, FN_INVERT_ALL: begin
            start_in = '0;
            end_in   = nm1;
            mod_in   = 1'b1;
            inv_in   = (req_fn == FN_INVERT_ALL);
         end
         FN_WRITE_WORD: begin
            oor_in = widx_bad;
         end
         FN_SHIFT_UP: begin
            up_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // read side of the walk
   always_comb begin
      q     = k_ff[9:5];
      r     = k_ff[4:0];
      rd_en = (state_ff == ST_SWEEP) && (step_ff <= ST_W'(NW));
      if (up_ff) begin
         sa = SA_W'(NW - 1) - SA_W'(q) - SA_W'(step_ff);
      end else begin
         sa = SA_W'(q) + SA_W'(step_ff);
      end
      rok_in   = rd_en && !sa[SA_W-1] && (sa < SA_W'(NW));
      rd_addr  = sa[AW-1:0];
      raddr_in = rd_addr;
      b_act_in = rd_en;
      b_step_in = step_ff;
   end

   // modify side of the walk
   always_comb begin
      cur      = rok_ff ? (rdat_ff & live_mask(raddr_ff, lw_ff)) : '0;
      prev_in  = b_act_ff ? cur : prev_ff;
      wr_en    = b_act_ff && (b_step_ff != '0);
      wi_full  = up_ff ? (ST_W'(NW) - b_step_ff) : (b_step_ff - 1'b1);
      wr_addr  = wi_full[AW-1:0];
      back_amt = 6'd32 - {1'b0, r};
      // two neighboring source words feed one result word
      if (up_ff) begin
         base_w = (prev_ff << r) | ((r == '0) ? 32'd0 : (cur >> back_amt));
      end else begin
         base_w = (prev_ff >> r) | ((r == '0) ? 32'd0 : (cur << back_amt));
      end
      lm   = live_mask(wr_addr, n);
      wi_c = CW'(wr_addr);
      sw_c = CW'(start_ff[SIZE_W-1:5]);
      ew_c = CW'(end_ff[SIZE_W-1:5]);
      ge   = (wi_c > sw_c) ? '1 : ((wi_c == sw_c) ? (32'hFFFF_FFFF << start_ff[4:0]) : '0);
      le   = (wi_c < ew_c) ? '1 :
             ((wi_c == ew_c) ? (32'hFFFF_FFFF >> (5'd31 - end_ff[4:0])) : '0);
      rm   = ge & le;
      mm   = mod_ff ? rm : '0;
      case (func_ff) inside
         FN_WRITE_BIT, FN_RANGE, FN_ALL, FN_INVERT_ALL, FN_INVERT_BIT: begin
            if (inv_ff) new_w = base_w ^ mm;
            else if (val_ff) new_w = base_w | mm;
            else new_w = base_w & ~mm;
         end
         FN_WRITE_WORD: begin
            new_w = (!oor_ff && (wi_c == CW'(widx_ff))) ? wdata_ff : base_w;
         end
         default: begin
            new_w = base_w;
         end
      endcase
      new_w = new_w & lm;

      pol  = val_ff ? base_w : ~base_w;
      cand = (func_ff == FN_FIND && !oor_ff) ? (pol & lm & rm) : '0;
      iso  = cand & (~cand + 32'd1);
      idx  = '0;
      for (int b = 0; b < 32; b++) begin
         if (iso[b]) idx = idx | 5'(b);
      end

      any_in   = any_ff;
      all_in   = all_ff;
      found_in = found_ff;
      fpos_in  = fpos_ff;
      tbit_in  = tbit_ff;
      if (wr_en) begin
         any_in = any_ff | (|new_w);
         all_in = all_ff & (new_w == lm);
         if (!found_ff && (cand != '0)) begin
            found_in = 1'b1;
            fpos_in  = POS_W'({wr_addr, idx});
         end
         if (func_ff == FN_TEST && !oor_ff && (wi_c == CW'(pos_ff[POS_W-1:5]))) begin
            tbit_in = base_w[pos_ff[4:0]];
         end
      end
      if (acc) begin
         any_in   = 1'b0;
         all_in   = 1'b1;
         found_in = 1'b0;
         fpos_in  = '0;
         tbit_in  = 1'b0;
      end
   end

   assign sweep_end = b_act_ff && (b_step_ff == ST_W'(NW));
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      size_in  = size_ff;
      lw_in    = lw_ff;
      k_in     = k_ff;
      func_in  = func_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      widx_in  = widx_ff;
      wdata_in = wdata_ff;
      if (csr_wr) begin
         size_in = pwdata[SIZE_W-1:0];
         lw_in   = (new_n < lw_ff) ? new_n : lw_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               func_in  = req_fn;
               val_in   = req.bit_value;
               pos_in   = req.bit_pos;
               widx_in  = req.word_index;
               wdata_in = req.word_data;
               k_in     = '0;
               step_in  = '0;
               state_in = div_ctl.start ? ST_DIV : ST_SWEEP;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               k_in     = div_sts.rem;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (step_ff <= ST_W'(NW)) step_in = step_ff + 1'b1;
            if (sweep_end) begin
               lw_in    = n;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         lw_ff        <= '0;
         b_act_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         lw_ff        <= lw_in;
         b_act_ff     <= b_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff   <= step_in;
      k_ff      <= k_in;
      func_ff   <= func_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      widx_ff   <= widx_in;
      wdata_ff  <= wdata_in;
      if (acc) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         mod_ff   <= mod_in;
         inv_ff   <= inv_in;
         oor_ff   <= oor_in;
         up_ff    <= up_in;
      end
      b_step_ff <= b_step_in;
      rok_ff    <= rok_in;
      raddr_ff  <= raddr_in;
      prev_ff   <= prev_in;
      any_ff    <= any_in;
      all_ff    <= all_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      tbit_ff   <= tbit_in;
      if (rsp_load) begin
         rsp_tbit_ff  <= tbit_ff;
         rsp_found_ff <= found_ff;
         rsp_fpos_ff  <= fpos_ff;
         rsp_any_ff   <= any_ff;
         rsp_all_ff   <= all_ff;
         rsp_oor_ff   <= oor_ff;
      end
   end

   // word memory
   always_ff @(posedge clock) begin
      rdat_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= new_w;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.test_bit     = rsp_tbit_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.found_pos    = rsp_fpos_ff;
   assign rsp.any_set      = rsp_any_ff;
   assign rsp.all_set      = rsp_all_ff;
   assign rsp.out_of_range = rsp_oor_ff;

`ifndef SYNTHESIS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rok_in) |-> (wr_addr != rd_addr))
      else $error("walk reads a word that is written in the same cycle");

   a_all_implies_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_all_ff || rsp_any_ff))
      else $error("all_set reported without any_set");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> !rsp_oor_ff)
      else $error("found reported for an out of range item");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIV))
      else $error("modulo result outside the modulo state");
`endif

endmodule

`default_nettype wire

### rtl/bse_mod_div.sv
`default_nettype none

module bse_mod_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bse_pkg::div_ctl_type  ctl,
   output bse_pkg::div_sts_type  sts
);
   import bse_pkg::*;

   localparam int STEP_W = $clog2(CNT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  dvd_ff, dvd_in;
   logic [SIZE_W-1:0] dsr_ff, dsr_in;
   logic [SIZE_W:0]   trial;

   // restoring remainder, one dividend bit a cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[CNT_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(CNT_W - 1);
         rem_in  = '0;
         dvd_in  = ctl.dividend;
         dsr_in  = ctl.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         dvd_in = dvd_ff << 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done = done_ff;
   assign sts.rem  = rem_ff[CNT_W-1:0];

endmodule

`default_nettype wire

### test/bitmap_set_engine_test.sv
`timescale 1ns / 1ps

module bitmap_set_engine_test;
   import bse_pkg::*;

   localparam int NBITS     = SIZE_BITS_DEF;
   localparam int CYCLE_CAP = 1000000;
   localparam int DRAIN     = 80;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  bit_pos;
      logic [POS_W-1:0]  range_end;
      logic              bit_value;
      logic [CNT_W-1:0]  shift_count;
      logic [WIDX_W-1:0] word_index;
      logic [31:0]       word_data;
   } op_item_type;

   typedef struct {
      logic             test_bit;
      logic             found;
      logic [POS_W-1:0] found_pos;
      logic             any_set;
      logic             all_set;
      logic             out_of_range;
   } bitmap_status_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   bse_req_if req_ch ();
   bse_rsp_if rsp_ch ();

   bitmap_set_engine uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready)
   );

   // shadow copy of the bitmap and its live size
   logic [NBITS-1:0]  shadow_bits;
   int unsigned       shadow_size;
   bitmap_status_type pending_status[$];
   int                fail_count;
   int unsigned       cycle_count;
   bit                idle_off;
   bit                hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("bitmap_set_engine_test NOT OK");
         $finish;
      end
   end

   function automatic logic [NBITS-1:0] live_mask_of(int unsigned n);
      logic [NBITS-1:0] m;
      m = '0;
      for (int i = 0; i < NBITS; i++) if (i < n) m[i] = 1'b1;
      return m;
   endfunction

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > NBITS) return NBITS;
      return 32'(v);
   endfunction

   function automatic bitmap_status_type apply_op(op_item_type it);
      bitmap_status_type st;
      logic [NBITS-1:0] mask;
      int unsigned n, rend, k;
      n = shadow_size;
      mask = live_mask_of(n);
      st = '{default: 1'b0};
      case (func_type'(it.func))
         FN_WRITE_BIT: begin
            if (it.bit_pos < n) shadow_bits[it.bit_pos] = it.bit_value;
            else st.out_of_range = 1'b1;
         end
         FN_TEST: begin
            if (it.bit_pos < n) st.test_bit = shadow_bits[it.bit_pos];
            else st.out_of_range = 1'b1;
         end
         FN_RANGE: begin
            if (it.bit_pos >= n) st.out_of_range = 1'b1;
            else begin
               rend = (it.range_end > n - 1) ? n - 1 : it.range_end;
               for (int i = it.bit_pos; i <= int'(rend); i++) shadow_bits[i] = it.bit_value;
            end
         end
         FN_ALL:        shadow_bits = it.bit_value ? mask : '0;
         FN_INVERT_ALL: shadow_bits = ~shadow_bits & mask;
         FN_INVERT_BIT: begin
            if (it.bit_pos < n) shadow_bits[it.bit_pos] = ~shadow_bits[it.bit_pos];
            else st.out_of_range = 1'b1;
         end
         FN_FIND: begin
            if (it.bit_pos >= n) st.out_of_range = 1'b1;
            else begin
               for (int i = it.bit_pos; i < int'(n); i++) begin
                  if (!st.found && shadow_bits[i] == it.bit_value) begin
                     st.found = 1'b1;
                     st.found_pos = i[POS_W-1:0];
                  end
               end
            end
         end
         FN_WRITE_WORD: begin
            if (it.word_index >= (n + 31) / 32) st.out_of_range = 1'b1;
            else shadow_bits[it.word_index*32 +: 32] = it.word_data & mask[it.word_index*32 +: 32];
         end
         FN_SHIFT_UP: begin
            k = it.shift_count % n;
            shadow_bits = (shadow_bits << k) & mask;
         end
         FN_SHIFT_DN: begin
            k = it.shift_count % n;
            shadow_bits = shadow_bits >> k;
         end
         default: ;
      endcase
      st.any_set = |shadow_bits;
      st.all_set = (shadow_bits == mask);
      return st;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_off || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_op(op_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.func        = it.func;
      req_ch.bit_pos     = it.bit_pos;
      req_ch.range_end   = it.range_end;
      req_ch.bit_value   = it.bit_value;
      req_ch.shift_count = it.shift_count;
      req_ch.word_index  = it.word_index;
      req_ch.word_data   = it.word_data;
      req_ch.valid       = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_status.push_back(apply_op(it));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      end_burst();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] v);
      wait_drained();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = '0;
      csr_pwdata = 32'(v);
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      shadow_size = clamp_size(v);
      shadow_bits &= live_mask_of(shadow_size);
   endtask

   function automatic op_item_type make_op(int f, int p, int e, int v, int c, int w, int d);
      op_item_type it;
      it.func = f[FUNC_W-1:0];
      it.bit_pos = p[POS_W-1:0];
      it.range_end = e[POS_W-1:0];
      it.bit_value = v[0];
      it.shift_count = c[CNT_W-1:0];
      it.word_index = w[WIDX_W-1:0];
      it.word_data = d;
      return it;
   endfunction

   function automatic op_item_type random_op();
      op_item_type it;
      int r;
      r = $urandom_range(0, 99);
      it.func = (r < 95) ? FUNC_W'($urandom_range(0, 9)) : FUNC_W'($urandom_range(10, 15));
      // mostly in-range positions so the operations really act
      if ($urandom_range(0, 9) < 8) it.bit_pos = POS_W'($urandom_range(0, shadow_size - 1));
      else it.bit_pos = POS_W'($urandom);
      if ($urandom_range(0, 3) == 0) it.range_end = POS_W'($urandom);
      else it.range_end = POS_W'(it.bit_pos + $urandom_range(0, 40));
      it.bit_value = 1'($urandom_range(0, 1));
      it.shift_count = CNT_W'($urandom);
      if ($urandom_range(0, 4) == 0) it.word_index = WIDX_W'($urandom);
      else it.word_index = WIDX_W'($urandom_range(0, (shadow_size - 1) / 32));
      it.word_data = $urandom;
      return it;
   endfunction

   task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      bitmap_status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t unexpected result, expected none actual %b%b%0d%b%b%b", $realtime,
                     rsp_ch.test_bit, rsp_ch.found, rsp_ch.found_pos, rsp_ch.any_set,
                     rsp_ch.all_set, rsp_ch.out_of_range);
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("test_bit", want.test_bit, rsp_ch.test_bit);
            check_field("found", want.found, rsp_ch.found);
            check_field("found_pos", want.found_pos, rsp_ch.found_pos);
            check_field("any_set", want.any_set, rsp_ch.any_set);
            check_field("all_set", want.all_set, rsp_ch.all_set);
            check_field("out_of_range", want.out_of_range, rsp_ch.out_of_range);
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      int hold;
      stall = 0;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready = 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!idle_off) stall = pick_gap();
         end
      end
   end

   task automatic test_directed();
      send_op(make_op(FN_ALL, 0, 0, 1, 0, 0, 0));
      send_op(make_op(FN_TEST, 1023, 0, 0, 0, 0, 0));
      send_op(make_op(FN_WRITE_BIT, 1023, 0, 0, 0, 0, 0));
      send_op(make_op(FN_FIND, 0, 0, 0, 0, 0, 0));
      send_op(make_op(FN_ALL, 0, 0, 0, 0, 0, 0));
      send_op(make_op(FN_WRITE_BIT, 0, 0, 1, 0, 0, 0));
      send_op(make_op(FN_RANGE, 5, 1023, 1, 0, 0, 0));
      send_op(make_op(FN_RANGE, 900, 100, 0, 0, 0, 0));
      send_op(make_op(FN_FIND, 1, 0, 1, 0, 0, 0));
      send_op(make_op(FN_FIND, 6, 0, 0, 0, 0, 0));
      send_op(make_op(FN_INVERT_ALL, 0, 0, 0, 0, 0, 0));
      send_op(make_op(FN_INVERT_BIT, 1023, 0, 0, 0, 0, 0));
      send_op(make_op(FN_WRITE_WORD, 0, 0, 0, 0, 31, 32'hFFFFFFFF));
      send_op(make_op(FN_SHIFT_UP, 0, 0, 0, 0, 0, 0));
      send_op(make_op(FN_SHIFT_UP, 0, 0, 0, 1023, 0, 0));
      send_op(make_op(FN_SHIFT_DN, 0, 0, 0, 33, 0, 0));
      send_op(make_op(FN_SHIFT_DN, 0, 0, 0, 64, 0, 0));
      send_op(make_op(4'd15, 0, 0, 0, 0, 0, 0));
      write_size(11'd33);
      send_op(make_op(FN_WRITE_WORD, 0, 0, 0, 0, 1, 32'hFFFFFFFF));
      send_op(make_op(FN_WRITE_WORD, 0, 0, 0, 0, 2, 32'h12345678));
      send_op(make_op(FN_TEST, 33, 0, 0, 0, 0, 0));
      send_op(make_op(FN_FIND, 40, 0, 1, 0, 0, 0));
      send_op(make_op(FN_RANGE, 33, 40, 1, 0, 0, 0));
      send_op(make_op(FN_SHIFT_UP, 0, 0, 0, 1023, 0, 0));
      wait_drained();
   endtask

   task automatic test_sizes();
      logic [SIZE_W-1:0] sizes[8];
      sizes = '{11'd1, 11'd0, 11'd32, 11'd31, 11'd2047, 11'd1000, 11'd64, 11'd1024};
      foreach (sizes[s]) begin
         write_size(sizes[s]);
         send_op(make_op(FN_ALL, 0, 0, 1, 0, 0, 0));
         repeat (40) send_op(random_op());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (30) send_op(random_op());
      wait_drained();
   endtask

   task automatic test_random();
      repeat (4) begin
         write_size(11'($urandom_range(1, NBITS)));
         idle_off = ($urandom_range(0, 2) == 0);
         repeat (105) send_op(random_op());
      end
      idle_off = 1'b0;
      write_size(11'd1024);
      repeat (100) send_op(random_op());
      wait_drained();
   endtask

   initial begin
      fail_count = 0;
      cycle_count = 0;
      idle_off = 1'b0;
      hold_request = 1'b0;
      shadow_bits = '0;
      shadow_size = NBITS;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.bit_pos = '0;
      req_ch.range_end = '0;
      req_ch.bit_value = 1'b0;
      req_ch.shift_count = '0;
      req_ch.word_index = '0;
      req_ch.word_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_sizes();
      test_backpressure();
      test_random();
      if (fail_count == 0) $display("bitmap_set_engine_test OK");
      else $display("bitmap_set_engine_test NOT OK");
      $finish;
   end

endmodule
